// ===== hdl/eihp_pkg.sv =====
// shared types and constants for the ethernet / ipv4 / l4 header parser
// no dependencies
package eihp_pkg;

  localparam int unsigned CNT_W = 14;
  localparam int unsigned CNT_MAX = (2 ** CNT_W) - 1;
  localparam int unsigned DEFAULT_MAX_FRAME_BYTES = 16383;

  typedef logic [CNT_W-1:0] count_t;
  typedef logic [CNT_W:0]   sum_t;

  // byte positions within the frame
  localparam count_t POS_SRC_MAC  = count_t'(6);
  localparam count_t POS_ETHER    = count_t'(12);
  localparam count_t POS_IP       = count_t'(14);
  localparam count_t POS_TTL      = count_t'(22);
  localparam count_t POS_PROTO    = count_t'(23);
  localparam count_t POS_ADDR     = count_t'(26);
  localparam count_t POS_ADDR_END = count_t'(34);

  // offsets within the l4 header
  localparam count_t L4_PORTS_END = count_t'(4);
  localparam count_t L4_SEQ_END   = count_t'(12);
  localparam count_t L4_OFFSET    = count_t'(12);
  localparam count_t L4_FLAGS     = count_t'(13);

  localparam sum_t ETH_LEN = sum_t'(14);
  localparam sum_t IP_MIN  = sum_t'(20);
  localparam sum_t TCP_MIN = sum_t'(20);
  localparam sum_t UDP_LEN = sum_t'(8);

  localparam logic [5:0]  HDR_MIN_BYTES  = 6'd20;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IPV4_VER       = 4'd4;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT_ETH   = 3'd1;
  localparam logic [2:0] ST_SHORT_IP    = 3'd2;
  localparam logic [2:0] ST_BAD_VERSION = 3'd3;
  localparam logic [2:0] ST_BAD_IP_HDR  = 3'd4;
  localparam logic [2:0] ST_SHORT_TCP   = 3'd5;
  localparam logic [2:0] ST_BAD_TCP_HDR = 3'd6;
  localparam logic [2:0] ST_SHORT_UDP   = 3'd7;

  localparam int unsigned LAYER_IP  = 0;
  localparam int unsigned LAYER_TCP = 1;
  localparam int unsigned LAYER_UDP = 2;

  typedef struct packed {
    count_t      byte_count;
    logic [5:0]  ip_hdr_bytes;
    logic [5:0]  l4_hdr_bytes;
    logic [3:0]  ip_ver;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_kind;
    logic [15:0] ttl_proto;
    logic [63:0] addrs;
    logic [31:0] ports;
    logic [63:0] seq_ack;
    logic [7:0]  flags;
  } frame_state_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  layer_mask;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_kind;
    logic [15:0] ttl_and_proto;
    logic [31:0] src_addr;
    logic [31:0] dest_addr;
    logic [31:0] port_pair;
    logic [63:0] seq_and_ack;
    logic [7:0]  flag_bits;
    count_t      payload_bytes;
  } result_t;

endpackage

// ===== hdl/eihp_frame_step.sv =====
// per-beat capture update and end-of-frame header checks
// depends on eihp_pkg
module eihp_frame_step #(
  parameter int unsigned MAX_FRAME_BYTES = eihp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  eihp_pkg::frame_state_t state_i,
  input  logic [7:0]             data_byte_i,
  output eihp_pkg::frame_state_t state_o,
  output eihp_pkg::result_t      result_o
);

  localparam eihp_pkg::count_t FrameCap = eihp_pkg::count_t'(
    (MAX_FRAME_BYTES > eihp_pkg::CNT_MAX) ? eihp_pkg::CNT_MAX : MAX_FRAME_BYTES);

  eihp_pkg::frame_state_t nxt;
  eihp_pkg::count_t       pos;
  eihp_pkg::count_t       l4_start;
  eihp_pkg::count_t       l4_pos;
  logic [7:0]             proto;

  assign pos      = state_i.byte_count;
  assign l4_start = eihp_pkg::POS_IP + eihp_pkg::count_t'(state_i.ip_hdr_bytes);
  assign l4_pos   = pos - l4_start;
  assign proto    = state_i.ttl_proto[7:0];

  always_comb begin
    nxt = state_i;
    if (pos < FrameCap) begin
      nxt.byte_count = pos + eihp_pkg::count_t'(1);
      if (pos < eihp_pkg::POS_SRC_MAC) begin
        nxt.dst_mac = {state_i.dst_mac[39:0], data_byte_i};
      end else if (pos < eihp_pkg::POS_ETHER) begin
        nxt.src_mac = {state_i.src_mac[39:0], data_byte_i};
      end else if (pos < eihp_pkg::POS_IP) begin
        nxt.ether_kind = {state_i.ether_kind[7:0], data_byte_i};
      end else if (state_i.ether_kind == eihp_pkg::ETHERTYPE_IPV4) begin
        if (pos == eihp_pkg::POS_IP) begin
          nxt.ip_ver       = data_byte_i[7:4];
          nxt.ip_hdr_bytes = {data_byte_i[3:0], 2'b00};
        end else if (pos == eihp_pkg::POS_TTL) begin
          nxt.ttl_proto[15:8] = data_byte_i;
        end else if (pos == eihp_pkg::POS_PROTO) begin
          nxt.ttl_proto[7:0] = data_byte_i;
        end else if (pos >= eihp_pkg::POS_ADDR && pos < eihp_pkg::POS_ADDR_END) begin
          nxt.addrs = {state_i.addrs[55:0], data_byte_i};
        end else if (state_i.ip_ver == eihp_pkg::IPV4_VER
                     && state_i.ip_hdr_bytes >= eihp_pkg::HDR_MIN_BYTES
                     && pos >= l4_start
                     && (proto == eihp_pkg::PROTO_TCP || proto == eihp_pkg::PROTO_UDP)) begin
          if (l4_pos < eihp_pkg::L4_PORTS_END) begin
            nxt.ports = {state_i.ports[23:0], data_byte_i};
          end else if (proto == eihp_pkg::PROTO_TCP) begin
            if (l4_pos < eihp_pkg::L4_SEQ_END) begin
              nxt.seq_ack = {state_i.seq_ack[55:0], data_byte_i};
            end else if (l4_pos == eihp_pkg::L4_OFFSET) begin
              nxt.l4_hdr_bytes = {data_byte_i[7:4], 2'b00};
            end else if (l4_pos == eihp_pkg::L4_FLAGS) begin
              nxt.flags = data_byte_i;
            end
          end
        end
      end
    end
  end

  assign state_o = nxt;

  eihp_pkg::sum_t len;
  eihp_pkg::sum_t ip_end;
  eihp_pkg::sum_t tcp_end;
  eihp_pkg::sum_t off;
  logic [2:0]     status;
  logic [2:0]     mask;
  logic [7:0]     fproto;

  assign len     = eihp_pkg::sum_t'(nxt.byte_count);
  assign ip_end  = eihp_pkg::ETH_LEN + eihp_pkg::sum_t'(nxt.ip_hdr_bytes);
  assign tcp_end = ip_end + eihp_pkg::sum_t'(nxt.l4_hdr_bytes);
  assign fproto  = nxt.ttl_proto[7:0];

  always_comb begin
    status = eihp_pkg::ST_OK;
    mask   = 3'b000;
    off    = eihp_pkg::ETH_LEN;
    if (len < eihp_pkg::ETH_LEN) begin
      status = eihp_pkg::ST_SHORT_ETH;
    end else if (nxt.ether_kind == eihp_pkg::ETHERTYPE_IPV4) begin
      if (len < eihp_pkg::ETH_LEN + eihp_pkg::IP_MIN) begin
        status = eihp_pkg::ST_SHORT_IP;
      end else if (nxt.ip_ver != eihp_pkg::IPV4_VER) begin
        status = eihp_pkg::ST_BAD_VERSION;
      end else if (nxt.ip_hdr_bytes < eihp_pkg::HDR_MIN_BYTES || len < ip_end) begin
        status = eihp_pkg::ST_BAD_IP_HDR;
      end else begin
        mask[eihp_pkg::LAYER_IP] = 1'b1;
        off = ip_end;
        if (fproto == eihp_pkg::PROTO_TCP) begin
          if (len < ip_end + eihp_pkg::TCP_MIN) begin
            status = eihp_pkg::ST_SHORT_TCP;
          end else if (nxt.l4_hdr_bytes < eihp_pkg::HDR_MIN_BYTES || len < tcp_end) begin
            status = eihp_pkg::ST_BAD_TCP_HDR;
          end else begin
            mask[eihp_pkg::LAYER_TCP] = 1'b1;
            off = tcp_end;
          end
        end else if (fproto == eihp_pkg::PROTO_UDP) begin
          if (len < ip_end + eihp_pkg::UDP_LEN) begin
            status = eihp_pkg::ST_SHORT_UDP;
          end else begin
            mask[eihp_pkg::LAYER_UDP] = 1'b1;
            off = ip_end + eihp_pkg::UDP_LEN;
          end
        end
      end
    end
  end

  logic ok;
  logic ip_ok;
  logic tcp_ok;
  logic l4_ok;

  assign ok     = (status == eihp_pkg::ST_OK);
  assign ip_ok  = ok && mask[eihp_pkg::LAYER_IP];
  assign tcp_ok = ok && mask[eihp_pkg::LAYER_TCP];
  assign l4_ok  = ok && (mask[eihp_pkg::LAYER_TCP] || mask[eihp_pkg::LAYER_UDP]);

  always_comb begin
    result_o               = '0;
    result_o.status        = status;
    if (ok) begin
      result_o.layer_mask  = mask;
      result_o.dst_mac     = nxt.dst_mac;
      result_o.src_mac     = nxt.src_mac;
      result_o.ether_kind  = nxt.ether_kind;
      result_o.payload_bytes = (len > off) ? eihp_pkg::count_t'(len - off) : '0;
    end
    if (ip_ok) begin
      result_o.ttl_and_proto = nxt.ttl_proto;
      result_o.src_addr      = nxt.addrs[63:32];
      result_o.dest_addr     = nxt.addrs[31:0];
    end
    if (l4_ok) begin
      result_o.port_pair = nxt.ports;
    end
    if (tcp_ok) begin
      result_o.seq_and_ack = nxt.seq_ack;
      result_o.flag_bits   = nxt.flags;
    end
  end

endmodule

// ===== hdl/eth_ipv4_l4_header_parser_unit.sv =====
// Ethernet / IPv4 / TCP / UDP header parser, top level with result buffering
// depends on eihp_pkg and eihp_frame_step
//
// Frames enter one byte per beat in wire order, with last_i on the final byte, and the
// unit takes a byte in every cycle while the skid entry is empty: each beat updates the
// byte counter and the capture registers in a single registered pass. The final byte
// of a frame produces one registered result beat, carrying status, layer mask, captured
// fields and payload length; capture state clears on that byte so the next frame may
// follow at once. Results sit in an output register backed by one skid entry; input
// stalls only while the skid entry is occupied. The byte count saturates at
// MAX_FRAME_BYTES (capped at 16383) and bytes beyond that capture nothing.
module eth_ipv4_l4_header_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = eihp_pkg::DEFAULT_MAX_FRAME_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [2:0]  layer_mask_o,
  output logic [47:0] dst_mac_o,
  output logic [47:0] src_mac_o,
  output logic [15:0] ether_kind_o,
  output logic [15:0] ttl_and_proto_o,
  output logic [31:0] src_addr_o,
  output logic [31:0] dest_addr_o,
  output logic [31:0] port_pair_o,
  output logic [63:0] seq_and_ack_o,
  output logic [7:0]  flag_bits_o,
  output logic [13:0] payload_bytes_o
);

  eihp_pkg::frame_state_t state_q, state_d;
  eihp_pkg::result_t      result;
  eihp_pkg::result_t      out_q, skid_q;
  logic                   out_valid_q, skid_valid_q;
  logic                   in_accept, produce, out_pop;

  eihp_frame_step #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_step (
    .state_i    (state_q),
    .data_byte_i(data_byte_i),
    .state_o    (state_d),
    .result_o   (result)
  );

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !skid_valid_q;
  assign produce    = in_accept && last_i;
  assign out_pop    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_accept) begin
      state_q <= last_i ? '0 : state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (produce) begin
      if (out_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) begin
        out_q <= skid_q;
      end
    end else if (produce) begin
      if (out_valid_q && !out_pop) begin
        skid_q <= result;
      end else begin
        out_q <= result;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign layer_mask_o    = out_q.layer_mask;
  assign dst_mac_o       = out_q.dst_mac;
  assign src_mac_o       = out_q.src_mac;
  assign ether_kind_o    = out_q.ether_kind;
  assign ttl_and_proto_o = out_q.ttl_and_proto;
  assign src_addr_o      = out_q.src_addr;
  assign dest_addr_o     = out_q.dest_addr;
  assign port_pair_o     = out_q.port_pair;
  assign seq_and_ack_o   = out_q.seq_and_ack;
  assign flag_bits_o     = out_q.flag_bits;
  assign payload_bytes_o = out_q.payload_bytes;

endmodule

// ===== tb/eihp_frame_checker.sv =====
`timescale 1ns / 1ps
// frame checker for the header parser: watches both channels, rebuilds every frame's result
// byte by byte and compares each result beat with the oldest prediction
// depends on eihp_pkg
module eihp_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [2:0]  layer_mask_i,
  input  logic [47:0] dst_mac_i,
  input  logic [47:0] src_mac_i,
  input  logic [15:0] ether_kind_i,
  input  logic [15:0] ttl_and_proto_i,
  input  logic [31:0] src_addr_i,
  input  logic [31:0] dest_addr_i,
  input  logic [31:0] port_pair_i,
  input  logic [63:0] seq_and_ack_i,
  input  logic [7:0]  flag_bits_i,
  input  logic [13:0] payload_bytes_i,
  output int unsigned mismatches_o,
  output int unsigned waiting_o,
  output int unsigned checked_o
);

  localparam int unsigned FRAME_CAP =
    (eihp_pkg::DEFAULT_MAX_FRAME_BYTES > eihp_pkg::CNT_MAX) ? eihp_pkg::CNT_MAX
                                                            : eihp_pkg::DEFAULT_MAX_FRAME_BYTES;

  eihp_pkg::frame_state_t st;
  eihp_pkg::result_t      pending_results[$];
  eihp_pkg::result_t      want;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_val);
    mismatches_o++;
    $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
  endtask

  task automatic capture_byte(input int unsigned p, input logic [7:0] b);
    int unsigned l4_at;
    int unsigned r;
    if (p < eihp_pkg::POS_SRC_MAC) st.dst_mac = {st.dst_mac[39:0], b};
    else if (p < eihp_pkg::POS_ETHER) st.src_mac = {st.src_mac[39:0], b};
    else if (p < eihp_pkg::POS_IP) st.ether_kind = {st.ether_kind[7:0], b};
    else if (st.ether_kind == eihp_pkg::ETHERTYPE_IPV4) begin
      if (p == eihp_pkg::POS_IP) begin
        st.ip_ver       = b[7:4];
        st.ip_hdr_bytes = {b[3:0], 2'b00};
      end else if (p == eihp_pkg::POS_TTL) st.ttl_proto[15:8] = b;
      else if (p == eihp_pkg::POS_PROTO) st.ttl_proto[7:0] = b;
      else if (p >= eihp_pkg::POS_ADDR && p < eihp_pkg::POS_ADDR_END)
        st.addrs = {st.addrs[55:0], b};
      else if (st.ip_ver == eihp_pkg::IPV4_VER &&
               st.ip_hdr_bytes >= eihp_pkg::HDR_MIN_BYTES) begin
        l4_at = eihp_pkg::ETH_LEN + st.ip_hdr_bytes;
        if (p >= l4_at && (st.ttl_proto[7:0] == eihp_pkg::PROTO_TCP ||
                           st.ttl_proto[7:0] == eihp_pkg::PROTO_UDP)) begin
          r = p - l4_at;
          if (r < eihp_pkg::L4_PORTS_END) st.ports = {st.ports[23:0], b};
          else if (st.ttl_proto[7:0] == eihp_pkg::PROTO_TCP) begin
            if (r < eihp_pkg::L4_SEQ_END) st.seq_ack = {st.seq_ack[55:0], b};
            else if (r == eihp_pkg::L4_OFFSET) st.l4_hdr_bytes = {b[7:4], 2'b00};
            else if (r == eihp_pkg::L4_FLAGS) st.flags = b;
          end
        end
      end
    end
  endtask

  function automatic eihp_pkg::result_t close_frame();
    int unsigned       len;
    int unsigned       off;
    logic [2:0]        stat;
    logic [2:0]        mask;
    logic [7:0]        proto;
    eihp_pkg::result_t res;
    len   = st.byte_count;
    off   = 0;
    stat  = eihp_pkg::ST_OK;
    mask  = '0;
    proto = st.ttl_proto[7:0];
    res   = '0;
    if (len < eihp_pkg::ETH_LEN) stat = eihp_pkg::ST_SHORT_ETH;
    else begin
      off = eihp_pkg::ETH_LEN;
      if (st.ether_kind == eihp_pkg::ETHERTYPE_IPV4) begin
        if (len < off + eihp_pkg::IP_MIN) stat = eihp_pkg::ST_SHORT_IP;
        else if (st.ip_ver != eihp_pkg::IPV4_VER) stat = eihp_pkg::ST_BAD_VERSION;
        else if (st.ip_hdr_bytes < eihp_pkg::HDR_MIN_BYTES || len < off + st.ip_hdr_bytes)
          stat = eihp_pkg::ST_BAD_IP_HDR;
        else begin
          mask[eihp_pkg::LAYER_IP] = 1'b1;
          off += st.ip_hdr_bytes;
          if (proto == eihp_pkg::PROTO_TCP) begin
            if (len < off + eihp_pkg::TCP_MIN) stat = eihp_pkg::ST_SHORT_TCP;
            else if (st.l4_hdr_bytes < eihp_pkg::HDR_MIN_BYTES ||
                     len < off + st.l4_hdr_bytes)
              stat = eihp_pkg::ST_BAD_TCP_HDR;
            else begin
              mask[eihp_pkg::LAYER_TCP] = 1'b1;
              off += st.l4_hdr_bytes;
            end
          end else if (proto == eihp_pkg::PROTO_UDP) begin
            if (len < off + eihp_pkg::UDP_LEN) stat = eihp_pkg::ST_SHORT_UDP;
            else begin
              mask[eihp_pkg::LAYER_UDP] = 1'b1;
              off += eihp_pkg::UDP_LEN;
            end
          end
        end
      end
    end
    res.status = stat;
    if (stat == eihp_pkg::ST_OK) begin
      res.layer_mask = mask;
      res.dst_mac    = st.dst_mac;
      res.src_mac    = st.src_mac;
      res.ether_kind = st.ether_kind;
      if (mask[eihp_pkg::LAYER_IP]) begin
        res.ttl_and_proto = st.ttl_proto;
        res.src_addr      = st.addrs[63:32];
        res.dest_addr     = st.addrs[31:0];
      end
      if (mask[eihp_pkg::LAYER_TCP] || mask[eihp_pkg::LAYER_UDP]) res.port_pair = st.ports;
      if (mask[eihp_pkg::LAYER_TCP]) begin
        res.seq_and_ack = st.seq_ack;
        res.flag_bits   = st.flags;
      end
      if (len > off) res.payload_bytes = eihp_pkg::count_t'(len - off);
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st = '0;
      pending_results.delete();
      mismatches_o = 0;
      checked_o    = 0;
      waiting_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", status_i, '0);
        end else begin
          want = pending_results.pop_front();
          checked_o++;
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (layer_mask_i !== want.layer_mask)
            report_mismatch("layer_mask", layer_mask_i, want.layer_mask);
          if (dst_mac_i !== want.dst_mac) report_mismatch("dst_mac", dst_mac_i, want.dst_mac);
          if (src_mac_i !== want.src_mac) report_mismatch("src_mac", src_mac_i, want.src_mac);
          if (ether_kind_i !== want.ether_kind)
            report_mismatch("ether_kind", ether_kind_i, want.ether_kind);
          if (ttl_and_proto_i !== want.ttl_and_proto)
            report_mismatch("ttl_and_proto", ttl_and_proto_i, want.ttl_and_proto);
          if (src_addr_i !== want.src_addr) report_mismatch("src_addr", src_addr_i, want.src_addr);
          if (dest_addr_i !== want.dest_addr)
            report_mismatch("dest_addr", dest_addr_i, want.dest_addr);
          if (port_pair_i !== want.port_pair)
            report_mismatch("port_pair", port_pair_i, want.port_pair);
          if (seq_and_ack_i !== want.seq_and_ack)
            report_mismatch("seq_and_ack", seq_and_ack_i, want.seq_and_ack);
          if (flag_bits_i !== want.flag_bits)
            report_mismatch("flag_bits", flag_bits_i, want.flag_bits);
          if (payload_bytes_i !== want.payload_bytes)
            report_mismatch("payload_bytes", payload_bytes_i, want.payload_bytes);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        // bytes past the saturation point capture nothing
        if (st.byte_count < FRAME_CAP) begin
          capture_byte(st.byte_count, data_byte_i);
          st.byte_count = st.byte_count + 1'b1;
        end
        if (last_i) begin
          pending_results.push_back(close_frame());
          st = '0;
        end
      end
      waiting_o <= pending_results.size();
    end
  end

endmodule

// ===== tb/eth_ipv4_l4_header_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// top of the header parser regression: clock, reset, frame stimulus and result-side stalls
// depends on eihp_pkg, eth_ipv4_l4_header_parser_unit and eihp_frame_checker
module eth_ipv4_l4_header_parser_unit_tb;

  typedef enum int unsigned {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MIX_BYTES   = 1000;
  localparam int unsigned TOTAL_BYTES = 1150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [2:0]  layer_mask;
  logic [47:0] dst_mac;
  logic [47:0] src_mac;
  logic [15:0] ether_kind;
  logic [15:0] ttl_and_proto;
  logic [31:0] src_addr;
  logic [31:0] dest_addr;
  logic [31:0] port_pair;
  logic [63:0] seq_and_ack;
  logic [7:0]  flag_bits;
  logic [13:0] payload_bytes;

  int unsigned mismatches;
  int unsigned waiting;
  int unsigned checked;

  logic [7:0]  frame_bytes[$];
  int unsigned frames_sent = 0;
  int unsigned bytes_sent = 0;
  int unsigned directed_frames;
  int unsigned directed_bytes;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  bit          sender_idle = 1'b1;
  bit          sink_idle = 1'b1;

  eth_ipv4_l4_header_parser_unit u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .last_i          (last_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .layer_mask_o    (layer_mask),
    .dst_mac_o       (dst_mac),
    .src_mac_o       (src_mac),
    .ether_kind_o    (ether_kind),
    .ttl_and_proto_o (ttl_and_proto),
    .src_addr_o      (src_addr),
    .dest_addr_o     (dest_addr),
    .port_pair_o     (port_pair),
    .seq_and_ack_o   (seq_and_ack),
    .flag_bits_o     (flag_bits),
    .payload_bytes_o (payload_bytes)
  );

  eihp_frame_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .data_byte_i     (data_byte),
    .last_i          (last_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .layer_mask_i    (layer_mask),
    .dst_mac_i       (dst_mac),
    .src_mac_i       (src_mac),
    .ether_kind_i    (ether_kind),
    .ttl_and_proto_i (ttl_and_proto),
    .src_addr_i      (src_addr),
    .dest_addr_i     (dest_addr),
    .port_pair_i     (port_pair),
    .seq_and_ack_i   (seq_and_ack),
    .flag_bits_i     (flag_bits),
    .payload_bytes_i (payload_bytes),
    .mismatches_o    (mismatches),
    .waiting_o       (waiting),
    .checked_o       (checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // random result-side stall bursts, started only while sink_idle is set
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 6);
    end else begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
        $display("eth_ipv4_l4_header_parser_unit regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    if (sender_idle && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) push_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic make_frame(input logic [15:0] etype, input logic [3:0] ver,
                            input logic [3:0] ihl, input logic [7:0] proto,
                            input logic [3:0] doff, input int unsigned len,
                            input fill_e fill);
    int unsigned l4_at;
    frame_bytes.delete();
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: frame_bytes.push_back(8'h00);
        FILL_ONES: frame_bytes.push_back(8'hFF);
        default:   frame_bytes.push_back(8'($urandom));
      endcase
    end
    if (len > eihp_pkg::POS_ETHER) frame_bytes[eihp_pkg::POS_ETHER] = etype[15:8];
    if (len > eihp_pkg::POS_ETHER + 1) frame_bytes[eihp_pkg::POS_ETHER + 1] = etype[7:0];
    if (len > eihp_pkg::POS_IP) frame_bytes[eihp_pkg::POS_IP] = {ver, ihl};
    if (len > eihp_pkg::POS_PROTO) frame_bytes[eihp_pkg::POS_PROTO] = proto;
    l4_at = eihp_pkg::ETH_LEN + 4 * ihl + eihp_pkg::L4_OFFSET;
    if (ihl >= 5 && len > l4_at) frame_bytes[l4_at] = {doff, frame_bytes[l4_at][3:0]};
  endtask

  task automatic random_frame();
    int unsigned pick;
    int unsigned need;
    int unsigned len;
    logic [15:0] etype;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [3:0]  doff;
    logic [7:0]  proto;
    fill_e       fill;
    pick  = $urandom_range(0, 99);
    etype = eihp_pkg::ETHERTYPE_IPV4;
    ver   = eihp_pkg::IPV4_VER;
    ihl   = 4'd5;
    doff  = 4'd5;
    fill  = FILL_RANDOM;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: proto = eihp_pkg::PROTO_TCP;
      4, 5, 6, 7: proto = eihp_pkg::PROTO_UDP;
      default:    proto = 8'($urandom);
    endcase
    if (pick < 70) begin
      // mostly well-formed headers, sometimes truncated
      if ($urandom_range(0, 19) == 0) ver = 4'($urandom);
      if ($urandom_range(0, 3) == 0) ihl = 4'($urandom_range(5, 15));
      else if ($urandom_range(0, 19) == 0) ihl = 4'($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) doff = 4'($urandom_range(5, 15));
      else if ($urandom_range(0, 19) == 0) doff = 4'($urandom_range(0, 4));
      need = eihp_pkg::ETH_LEN + 4 * ihl +
             (proto == eihp_pkg::PROTO_TCP ? 4 * doff :
              (proto == eihp_pkg::PROTO_UDP ? eihp_pkg::UDP_LEN : 0));
      len  = ($urandom_range(0, 5) == 0) ? $urandom_range(1, need)
                                         : need + $urandom_range(0, 24);
    end else begin
      if (pick < 85) etype = 16'($urandom);
      ver  = 4'($urandom);
      ihl  = 4'($urandom);
      doff = 4'($urandom);
      len  = $urandom_range(1, 100);
    end
    if ($urandom_range(0, 29) == 0) fill = FILL_ONES;
    else if ($urandom_range(0, 29) == 0) fill = FILL_ZERO;
    make_frame(etype, ver, ihl, proto, doff, len, fill);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short ethernet, non-ip, every ip/l4 error and the length boundaries
    make_frame(16'hFFFF, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd5, 1, FILL_ONES);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd5,
               13, FILL_ZERO);
    send_frame();
    make_frame(16'hFFFF, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd5, 14, FILL_RANDOM);
    send_frame();
    make_frame(16'h86DD, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_UDP, 4'd5, 20, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd5,
               33, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, 4'd6, 4'd5, eihp_pkg::PROTO_TCP, 4'd5, 34,
               FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, 4'd0, 4'd0, eihp_pkg::PROTO_UDP, 4'd5, 34,
               FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd4, eihp_pkg::PROTO_TCP, 4'd5,
               40, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd0, eihp_pkg::PROTO_TCP, 4'd5,
               40, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd15, eihp_pkg::PROTO_TCP, 4'd5,
               50, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, 8'd1, 4'd5, 34,
               FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd5,
               53, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd4,
               54, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd15,
               60, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd5,
               54, FILL_ONES);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_TCP, 4'd5,
               54, FILL_ZERO);
    send_frame();
    // largest headers with nothing after them
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd15, eihp_pkg::PROTO_TCP, 4'd15,
               134, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_UDP, 4'd5,
               41, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd5, eihp_pkg::PROTO_UDP, 4'd5,
               42, FILL_RANDOM);
    send_frame();
    make_frame(eihp_pkg::ETHERTYPE_IPV4, eihp_pkg::IPV4_VER, 4'd6, eihp_pkg::PROTO_UDP, 4'd5,
               50, FILL_ONES);
    send_frame();
    wait_drained();
    directed_frames = frames_sent;
    directed_bytes  = bytes_sent;

    while (bytes_sent < MIX_BYTES) begin
      sender_idle = ($urandom_range(0, 3) != 0);
      sink_idle  <= ($urandom_range(0, 3) != 0);
      random_frame();
      send_frame();
    end

    // closing stretch at full rate on both sides
    sender_idle = 1'b0;
    sink_idle  <= 1'b0;
    while (bytes_sent < TOTAL_BYTES) begin
      random_frame();
      send_frame();
    end
    wait_drained();
    repeat (8) @(posedge clk);

    $display("sent %0d frames (%0d bytes), %0d directed (%0d bytes); %0d result beats compared",
             frames_sent, bytes_sent, directed_frames, directed_bytes, checked);
    $display("covered all status codes, tcp/udp/other l4, header extremes and zero payload");
    if (mismatches == 0) begin
      $display("eth_ipv4_l4_header_parser_unit regression: pass");
    end else begin
      $display("eth_ipv4_l4_header_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
